// ===== hdl/lfu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared sizes and types for the LFU cache with LRU tie-break.
// ----------------------------------------------------------------------------
package lfu_pkg;
  localparam int Capacity   = 16;
  localparam int CountWidth = 16;
  localparam int IdxW       = $clog2(Capacity);
  localparam int OccW       = $clog2(Capacity + 1);
  localparam int CapW       = 5;
  localparam int KeyW       = 32;
  localparam int InW        = 72;   // 65 bits of fields, padded to bytes
  localparam int OutW       = 72;   // 66 bits of fields, padded to bytes

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam logic [CountWidth-1:0] CountMax = '1;

  // one stored entry; the RAM word
  typedef struct packed {
    logic [KeyW-1:0]       key;
    logic [KeyW-1:0]       value;
    logic [CountWidth-1:0] count;
    logic [IdxW-1:0]       rank;
  } entry_t;
endpackage

// ===== hdl/lfu_cache_with_lru_tiebreak.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_with_lru_tiebreak
// Fully associative key/value cache, LFU replacement, LRU among equal counts.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis_* carries one item: tdata = {write_value, lookup_key, command},
//   command in bit 0. m_axis_* returns one result per item: tdata =
//   {evicted_key, evicted, read_value, hit}, hit in bit 0.
//   cfg_we/cfg_wdata write capacity_in_use (reset 16, values above 16 act
//   as 16, zero ignores puts); write it only while the block is idle.
// Timing:
//   Entries sit in one synchronous RAM (one read, one write per cycle).
//   The block takes one item at a time. A first pass (SCAN) reads all 16
//   entries to find the hit and the victim, DECIDE writes the touched
//   entry, and a second pass (AGE) ages by read-modify-write the other
//   valid entries ranked below the touched entry's old rank (all of them
//   when a free slot is filled); the result is then valid, and the next
//   item is taken only after the result is taken. Gets that miss and puts
//   ignored at capacity zero skip the second pass.
// Reset:
//   rst clears valid bits, occupancy and control; RAM contents stay
//   undefined and are never used before written.
// Stall:
//   The result is held in the output register until m_axis_tready; a new
//   item is not taken while it waits.
module lfu_cache_with_lru_tiebreak (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [lfu_pkg::CapW-1:0] cfg_wdata,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // [0] command, [32:1] lookup_key, [64:33] write_value
  input  logic [lfu_pkg::InW-1:0] s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // [0] hit, [32:1] read_value, [33] evicted, [65:34] evicted_key
  output logic [lfu_pkg::OutW-1:0] m_axis_tdata
);
  import lfu_pkg::*;

  typedef enum logic [2:0] {IDLE, SCAN, DECIDE, AGE, DONE} state_t;

  entry_t ram [Capacity];
  entry_t rd_q;
  logic [IdxW-1:0] rd_addr;
  logic            we;
  logic [IdxW-1:0] wr_addr;
  entry_t          wr_data;

  always_ff @(posedge clk) begin
    if (we) ram[wr_addr] <= wr_data;
    rd_q <= ram[rd_addr];
  end

  state_t state;
  logic [Capacity-1:0] valid;
  logic [OccW-1:0]  occ;
  logic [CapW-1:0]  cap_reg;
  logic             cmd;
  logic [KeyW-1:0]  key, val;
  logic [IdxW:0]    cnt;          // issue counter, one past the depth
  logic [IdxW-1:0]  pidx;         // index of the word in rd_q
  logic             pv;           // rd_q holds a word of this pass
  logic             found;
  logic [IdxW-1:0]  hit_idx;
  entry_t           hit_ent;
  logic             vic_ok;
  logic [IdxW-1:0]  vic_idx;
  entry_t           vic_ent;
  logic [IdxW-1:0]  slot;
  logic [IdxW:0]    old_rank;     // top bit: every entry ages
  logic             r_hit, r_ev;
  logic [KeyW-1:0]  r_rd, r_evk;
  logic [IdxW-1:0]  free_idx;
  logic             do_ins, do_upd;
  logic [OccW-1:0]  cap_eff;
  logic             evict_now;
  logic [IdxW-1:0]  slot_sel;

  assign cap_eff = (cap_reg > CapW'(Capacity)) ? OccW'(Capacity) : OccW'(cap_reg);

  always_comb begin
    free_idx = '0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (!valid[i]) free_idx = IdxW'(i);
    end
  end

  assign s_axis_tready = (state == IDLE);
  assign rd_addr = cnt[IdxW-1:0];
  assign m_axis_tdata = {6'd0, r_evk, r_ev, r_rd, r_hit};

  // write port: entry update in DECIDE, aging in AGE
  always_comb begin
    we      = 1'b0;
    wr_addr = slot;
    wr_data = hit_ent;
    if (state == DECIDE && (do_ins || do_upd)) begin
      we      = 1'b1;
      wr_addr = slot_sel;
      if (do_upd) begin
        wr_data.value = (cmd == CMD_PUT) ? val : hit_ent.value;
        wr_data.count = (hit_ent.count == CountMax) ? hit_ent.count
                                                    : hit_ent.count + 1'b1;
      end else begin
        wr_data.key   = key;
        wr_data.value = val;
        wr_data.count = CountWidth'(1);
      end
      wr_data.rank = '0;
    end else if (state == AGE && pv && pidx != slot && valid[pidx]
                 && {1'b0, rd_q.rank} < old_rank) begin
      we      = 1'b1;
      wr_addr = pidx;
      wr_data = rd_q;
      wr_data.rank = rd_q.rank + 1'b1;
    end
  end

  assign do_upd = found && (cmd == CMD_GET || cap_eff != '0);
  assign do_ins = !found && cmd == CMD_PUT && cap_eff != '0;

  // entry touched in DECIDE: the hit, else the victim when full, else a free one
  assign evict_now = occ >= cap_eff || occ >= OccW'(Capacity);
  assign slot_sel  = do_upd ? hit_idx : (evict_now ? vic_idx : free_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      valid         <= '0;
      occ           <= '0;
      cap_reg       <= CapW'(Capacity);
      m_axis_tvalid <= 1'b0;
      pv            <= 1'b0;
      cnt           <= '0;
    end else begin
      if (cfg_we) cap_reg <= cfg_wdata;
      unique case (state)
        IDLE: begin
          if (s_axis_tvalid) begin
            cmd    <= s_axis_tdata[0];
            key    <= s_axis_tdata[32:1];
            val    <= s_axis_tdata[64:33];
            found  <= 1'b0;
            vic_ok <= 1'b0;
            cnt    <= '0;
            pv     <= 1'b0;
            state  <= SCAN;
          end
        end
        SCAN: begin
          // compare the word read last cycle, issue the next read
          if (pv && valid[pidx]) begin
            if (!found && rd_q.key == key) begin
              found   <= 1'b1;
              hit_idx <= pidx;
              hit_ent <= rd_q;
            end
            if (!vic_ok || rd_q.count < vic_ent.count ||
                (rd_q.count == vic_ent.count && rd_q.rank > vic_ent.rank)) begin
              vic_ok  <= 1'b1;
              vic_idx <= pidx;
              vic_ent <= rd_q;
            end
          end
          pidx <= cnt[IdxW-1:0];
          if (cnt == (IdxW+1)'(Capacity)) begin
            pv    <= 1'b0;
            state <= DECIDE;
          end else begin
            pv  <= 1'b1;
            cnt <= cnt + 1'b1;
          end
        end
        DECIDE: begin
          r_hit <= do_upd;
          r_rd  <= (found && cmd == CMD_GET) ? hit_ent.value : '1;
          r_ev  <= 1'b0;
          r_evk <= '0;
          cnt   <= '0;
          if (do_upd) begin
            slot     <= hit_idx;
            old_rank <= {1'b0, hit_ent.rank};
            state    <= AGE;
          end else if (do_ins) begin
            state <= AGE;
            if (evict_now) begin
              r_ev     <= 1'b1;
              r_evk    <= vic_ent.key;
              slot     <= vic_idx;
              old_rank <= {1'b0, vic_ent.rank};
            end else begin
              slot            <= free_idx;
              old_rank        <= '1;
              valid[free_idx] <= 1'b1;
              occ             <= occ + 1'b1;
            end
          end else begin
            m_axis_tvalid <= 1'b1;
            state         <= DONE;
          end
        end
        AGE: begin
          pidx <= cnt[IdxW-1:0];
          if (cnt == (IdxW+1)'(Capacity)) begin
            pv            <= 1'b0;
            m_axis_tvalid <= 1'b1;
            state         <= DONE;
          end else begin
            pv  <= 1'b1;
            cnt <= cnt + 1'b1;
          end
        end
        DONE: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state         <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/lfu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_checker
// Port-level checks for the LFU cache.
// ----------------------------------------------------------------------------
module lfu_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [lfu_pkg::InW-1:0]   s_axis_tdata,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [lfu_pkg::OutW-1:0]  m_axis_tdata
);
  import lfu_pkg::*;

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_ev_put: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[33] |-> !m_axis_tdata[0])
    else $error("eviction on hit");
  a_get_rd: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[32:1] == '1)
    else $error("miss value not -1");
  a_accept_gap: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("back-to-back accept");
endmodule

bind lfu_cache_with_lru_tiebreak lfu_checker u_lfu_checker (.*);

// ===== bench/lfu_cache_with_lru_tiebreak_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_with_lru_tiebreak_tb
// Self-checking bench for the LFU cache with LRU tie-break. A behavioral
// cache model predicts hit, read value and eviction for every item; the
// monitor compares each result against the oldest prediction. Phases sweep
// the capacity register and the idle/stall patterns on both stream sides.
// ----------------------------------------------------------------------------
module lfu_cache_with_lru_tiebreak_tb;
  import lfu_pkg::*;

  localparam int Latency = 2 * Capacity + 8;
  localparam longint Limit = 3000000;

  typedef struct packed {
    logic [31:0] wval;
    logic [31:0] key;
    logic        cmd;
  } op_t;

  typedef struct packed {
    logic [31:0] evk;
    logic        ev;
    logic [31:0] rd;
    logic        hit;
  } res_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CapW-1:0] cfg_wdata = '0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [InW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OutW-1:0] m_axis_tdata;

  lfu_cache_with_lru_tiebreak u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  // cache model state
  logic [CapW-1:0]       cap_reg;
  logic                  c_valid [Capacity];
  logic [31:0]           c_key   [Capacity];
  logic [31:0]           c_val   [Capacity];
  logic [CountWidth-1:0] c_cnt   [Capacity];
  int unsigned           c_rank  [Capacity];
  int unsigned           c_occ;

  op_t  pending_ops[$];
  res_t expected_results[$];
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   errors = 0;
  int   results_seen = 0;
  int   hits_seen = 0;
  int   evictions_seen = 0;
  longint cycles = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH result %0d %s: got %h want %h", results_seen, what, got, want);
    errors++;
  endtask

  function automatic void cache_clear();
    for (int i = 0; i < Capacity; i++) begin
      c_valid[i] = 0; c_key[i] = 0; c_val[i] = 0; c_cnt[i] = 0; c_rank[i] = 0;
    end
    c_occ = 0;
    cap_reg = CapW'(Capacity);
  endfunction

  function automatic void touch(int s, int unsigned old_rank);
    for (int i = 0; i < Capacity; i++)
      if (i != s && c_valid[i] && c_rank[i] < old_rank) c_rank[i]++;
    c_rank[s] = 0;
  endfunction

  function automatic res_t cache_access(op_t op);
    res_t r;
    int found;
    int slot;
    int unsigned cap;
    int unsigned old_rank;
    r = '{evk: 32'd0, ev: 1'b0, rd: 32'hFFFF_FFFF, hit: 1'b0};
    cap = (cap_reg > Capacity) ? Capacity : cap_reg;
    found = -1;
    for (int i = 0; i < Capacity; i++)
      if (found < 0 && c_valid[i] && c_key[i] == op.key) found = i;
    if (op.cmd == CMD_GET) begin
      if (found >= 0) begin
        r.hit = 1; r.rd = c_val[found];
        if (c_cnt[found] != CountMax) c_cnt[found]++;
        touch(found, c_rank[found]);
      end
    end else if (cap != 0) begin
      if (found >= 0) begin
        r.hit = 1; c_val[found] = op.wval;
        if (c_cnt[found] != CountMax) c_cnt[found]++;
        touch(found, c_rank[found]);
      end else begin
        slot = -1;
        if (c_occ >= cap) begin
          for (int i = 0; i < Capacity; i++) begin
            if (c_valid[i] && (slot < 0 || c_cnt[i] < c_cnt[slot] ||
                (c_cnt[i] == c_cnt[slot] && c_rank[i] > c_rank[slot])))
              slot = i;
          end
        end
        if (slot >= 0) begin
          r.ev = 1; r.evk = c_key[slot]; old_rank = c_rank[slot];
        end else begin
          for (int i = Capacity - 1; i >= 0; i--) if (!c_valid[i]) slot = i;
          old_rank = 32'hFFFF_FFFF;
          c_occ++;
        end
        c_valid[slot] = 1; c_key[slot] = op.key; c_val[slot] = op.wval;
        c_cnt[slot] = CountWidth'(1);
        touch(slot, old_rank);
      end
    end
    return r;
  endfunction

  initial begin
    forever #10 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      s_axis_tvalid <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        op_t op;
        op = pending_ops.pop_front();
        expected_results.push_back(cache_access(op));
        s_axis_tdata <= {{(InW - 65){1'b0}}, op};
        s_axis_tvalid <= 1;
      end else begin
        s_axis_tvalid <= 0;
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      res_t got;
      res_t want;
      got = m_axis_tdata[65:0];
      if (expected_results.size() == 0) begin
        $display("MISMATCH unexpected result %h", got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
        if (got.rd !== want.rd) report_mismatch("read_value", got.rd, want.rd);
        if (got.ev !== want.ev) report_mismatch("evicted", got.ev, want.ev);
        if (got.evk !== want.evk) report_mismatch("evicted_key", got.evk, want.evk);
        if (want.hit) hits_seen++;
        if (want.ev) evictions_seen++;
      end
      results_seen++;
    end
    if (cycles > Limit) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic op_t make_op(logic cmd, logic [31:0] key, logic [31:0] wval);
    op_t op;
    op.cmd = cmd; op.key = key; op.wval = wval;
    return op;
  endfunction

  // mostly small key pool so hits and evictions are common
  function automatic logic [31:0] pick_key(int unsigned pool);
    logic [31:0] k;
    k = 32'($urandom_range(pool - 1));
    k[31] = 1'($urandom_range(1));
    if ($urandom_range(9) == 0) k = $urandom();
    return k;
  endfunction

  task automatic drain();
    while (pending_ops.size() != 0 || expected_results.size() != 0 || s_axis_tvalid)
      @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] v);
    @(posedge clk);
    cfg_we <= 1; cfg_wdata <= v;
    cap_reg = v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_burst(int n, int unsigned pool);
    for (int i = 0; i < n; i++)
      pending_ops.push_back(make_op(1'($urandom_range(1)), pick_key(pool), $urandom()));
  endtask

  initial begin
    logic [CapW-1:0] caps[8] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd17, 5'd2, 5'd9};
    int idle_s[4] = '{0, 88, 0, 18};
    int idle_r[4] = '{0, 0, 88, 18};
    cache_clear();
    repeat (6) @(posedge clk);
    rst <= 0;

    // directed: extreme keys/values, hits, misses, eviction, tie-break
    pending_ops.push_back(make_op(CMD_GET, 32'h8000_0000, 32'h0));
    pending_ops.push_back(make_op(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF));
    pending_ops.push_back(make_op(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000));
    pending_ops.push_back(make_op(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_ops.push_back(make_op(CMD_PUT, 32'h0, 32'h0));
    pending_ops.push_back(make_op(CMD_GET, 32'h8000_0000, 32'h0));
    pending_ops.push_back(make_op(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    pending_ops.push_back(make_op(CMD_PUT, 32'h0, 32'h1234_5678));
    pending_ops.push_back(make_op(CMD_GET, 32'h0, 32'h0));
    pending_ops.push_back(make_op(CMD_GET, 32'h5555_5555, 32'h0));
    for (int k = 0; k < 14; k++)
      pending_ops.push_back(make_op(CMD_PUT, 32'h100 + k, 32'hAAAA_0000 + k));
    drain();
    // lowered capacity below occupancy: puts evict without growing
    write_capacity(5'd3);
    pending_ops.push_back(make_op(CMD_PUT, 32'hDEAD_BEEF, 32'h1));
    pending_ops.push_back(make_op(CMD_GET, 32'hDEAD_BEEF, 32'h0));
    drain();

    for (int ph = 0; ph < 16; ph++) begin
      write_capacity(caps[ph % 8]);
      send_idle_pct = idle_s[ph % 4];
      recv_stall_pct = idle_r[ph % 4];
      random_burst(ph == 5 ? 20 : 117, (ph % 3 == 0) ? 6 : 24);
      drain();
    end

    // count saturation: one key hammered well past 2^16 is too long, so
    // hammer a key and check ordering logic; saturation reached only if
    // the count width is small
    send_idle_pct = 0; recv_stall_pct = 0;
    write_capacity(5'd2);
    for (int i = 0; i < 60; i++)
      pending_ops.push_back(make_op(CMD_GET, 32'h0, 32'h0));
    random_burst(40, 4);
    drain();

    $display("covered %0d items, %0d hits, %0d evictions across capacity and stall phases",
             results_seen, hits_seen, evictions_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
